/* src/c8alu_pkg.sv */
// Shared types and constants of the 8-bit CPU ALU with decimal mode.
// Used by c8alu_bcd, c8alu_exec and the top level cpu8_alu_bcd_rmw_core.
package c8alu_pkg;

  typedef enum logic [3:0] {
    MODE_ADC = 4'd0,
    MODE_SBC = 4'd1,
    MODE_ASL = 4'd2,
    MODE_LSR = 4'd3,
    MODE_ROL = 4'd4,
    MODE_ROR = 4'd5,
    MODE_INC = 4'd6,
    MODE_DEC = 4'd7,
    MODE_RMB = 4'd8,
    MODE_SMB = 4'd9,
    MODE_TRB = 4'd10,
    MODE_TSB = 4'd11,
    MODE_BBR = 4'd12,
    MODE_BBS = 4'd13
  } alu_mode_e;

  // Bit positions in the flag update mask.
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 2;
  localparam int unsigned FLAG_N = 3;

  localparam logic [3:0] MASK_NONE = 4'b0000;
  localparam logic [3:0] MASK_Z    = 4'b0010;
  localparam logic [3:0] MASK_ZN   = 4'b1010;
  localparam logic [3:0] MASK_CZN  = 4'b1011;
  localparam logic [3:0] MASK_ALL  = 4'b1111;

  // Decimal digit limit and adjustment.
  localparam logic [4:0] BCD_MAX_DIGIT = 5'd9;
  localparam logic [4:0] BCD_ADJ       = 5'd6;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] acc;
    logic [7:0] operand;
    logic       carry_in;
    logic       decimal;
    logic [2:0] bit_index;
  } alu_op_t;

  typedef struct packed {
    logic [7:0] result;
    logic       carry;
    logic       overflow;
  } bcd_res_t;

  typedef struct packed {
    logic [7:0] result;
    logic       carry_out;
    logic       zero_out;
    logic       overflow_out;
    logic       negative_out;
    logic [3:0] flag_update;
    logic       branch_taken;
  } alu_res_t;

endpackage

/* src/c8alu_bcd.sv */
// Decimal (BCD) add and subtract with carry and overflow.
// Depends on c8alu_pkg for the result struct and digit constants.
module c8alu_bcd
  import c8alu_pkg::*;
(
  input  logic [7:0] acc_i,
  input  logic [7:0] operand_i,
  input  logic       carry_in_i,
  output bcd_res_t   add_o,
  output bcd_res_t   sub_o
);

  logic [4:0] add_lo;
  logic [4:0] add_lo_fix;
  logic       add_hc;
  logic [4:0] add_hi;
  logic [4:0] add_hi_fix;

  logic       borrow;
  logic [7:0] sub_bin;
  logic [4:0] sub_lo;
  logic [3:0] sub_lo_fix;
  logic       sub_hb;
  logic [4:0] sub_hi;
  logic [3:0] sub_hi_fix;

  always_comb begin
    add_lo = {1'b0, acc_i[3:0]} + {1'b0, operand_i[3:0]} + {4'd0, carry_in_i};
    add_hc = (add_lo > BCD_MAX_DIGIT);
    add_lo_fix = add_hc ? ((add_lo + BCD_ADJ) & 5'h0F) : add_lo;
    add_hi = {1'b0, acc_i[7:4]} + {1'b0, operand_i[7:4]} + {4'd0, add_hc};
    // Overflow is judged on the high digit before its correction.
    add_o.overflow = (add_hi[3] ^ acc_i[7]) & ~(acc_i[7] ^ operand_i[7]);
    add_o.carry    = (add_hi > BCD_MAX_DIGIT);
    add_hi_fix     = add_o.carry ? (add_hi + BCD_ADJ) : add_hi;
    add_o.result   = {add_hi_fix[3:0], add_lo_fix[3:0]};
  end

  always_comb begin
    borrow  = ~carry_in_i;
    sub_bin = acc_i - operand_i - {7'd0, borrow};
    // Bit 4 of a digit difference is set exactly when the digit went negative.
    sub_lo  = {1'b0, acc_i[3:0]} - {1'b0, operand_i[3:0]} - {4'd0, borrow};
    sub_hb  = sub_lo[4];
    sub_lo_fix = sub_hb ? (sub_lo[3:0] - BCD_ADJ[3:0]) : sub_lo[3:0];
    sub_hi  = {1'b0, acc_i[7:4]} - {1'b0, operand_i[7:4]} - {4'd0, sub_hb};
    sub_hi_fix = sub_hi[4] ? (sub_hi[3:0] - BCD_ADJ[3:0]) : sub_hi[3:0];
    sub_o.carry    = ~sub_hi[4];
    sub_o.overflow = (operand_i[7] ^ acc_i[7]) & ~(sub_bin[7] ^ operand_i[7]);
    sub_o.result   = {sub_hi_fix, sub_lo_fix};
  end

endmodule

/* src/c8alu_exec.sv */
// Operation decode and result/flag selection for one ALU item.
// Depends on c8alu_pkg and instantiates c8alu_bcd for decimal ADC/SBC.
module c8alu_exec
  import c8alu_pkg::*;
(
  input  alu_op_t  op_i,
  output alu_res_t res_o
);

  bcd_res_t   bcd_add;
  bcd_res_t   bcd_sub;
  logic [7:0] bit_mask;
  logic [7:0] add_rhs;
  logic [8:0] bin_sum;
  logic       bin_ovf;
  logic [7:0] res;
  logic       cf;
  logic       zf;
  logic       vf;
  logic [3:0] mask;
  logic       br;
  logic       z_from_and;

  c8alu_bcd u_bcd (
    .acc_i      (op_i.acc),
    .operand_i  (op_i.operand),
    .carry_in_i (op_i.carry_in),
    .add_o      (bcd_add),
    .sub_o      (bcd_sub)
  );

  // Binary SBC is ADC of the inverted operand.
  assign add_rhs  = (alu_mode_e'(op_i.mode) == MODE_SBC) ? ~op_i.operand : op_i.operand;
  assign bin_sum  = {1'b0, op_i.acc} + {1'b0, add_rhs} + {8'd0, op_i.carry_in};
  assign bin_ovf  = ~(op_i.acc[7] ^ add_rhs[7]) & (op_i.acc[7] ^ bin_sum[7]);
  assign bit_mask = 8'b1 << op_i.bit_index;

  always_comb begin
    res        = op_i.operand;
    cf         = 1'b0;
    zf         = 1'b0;
    vf         = 1'b0;
    mask       = MASK_NONE;
    br         = 1'b0;
    z_from_and = 1'b0;
    case (alu_mode_e'(op_i.mode))
      MODE_ADC: begin
        mask = MASK_ALL;
        if (op_i.decimal) begin
          res = bcd_add.result;
          cf  = bcd_add.carry;
          vf  = bcd_add.overflow;
        end else begin
          res = bin_sum[7:0];
          cf  = bin_sum[8];
          vf  = bin_ovf;
        end
      end
      MODE_SBC: begin
        mask = MASK_ALL;
        if (op_i.decimal) begin
          res = bcd_sub.result;
          cf  = bcd_sub.carry;
          vf  = bcd_sub.overflow;
        end else begin
          res = bin_sum[7:0];
          cf  = bin_sum[8];
          vf  = bin_ovf;
        end
      end
      MODE_ASL: begin
        mask = MASK_CZN;
        cf   = op_i.operand[7];
        res  = {op_i.operand[6:0], 1'b0};
      end
      MODE_LSR: begin
        mask = MASK_CZN;
        cf   = op_i.operand[0];
        res  = {1'b0, op_i.operand[7:1]};
      end
      MODE_ROL: begin
        mask = MASK_CZN;
        cf   = op_i.operand[7];
        res  = {op_i.operand[6:0], op_i.carry_in};
      end
      MODE_ROR: begin
        mask = MASK_CZN;
        cf   = op_i.operand[0];
        res  = {op_i.carry_in, op_i.operand[7:1]};
      end
      MODE_INC: begin
        mask = MASK_ZN;
        res  = op_i.operand + 8'd1;
      end
      MODE_DEC: begin
        mask = MASK_ZN;
        res  = op_i.operand - 8'd1;
      end
      MODE_RMB: res = op_i.operand & ~bit_mask;
      MODE_SMB: res = op_i.operand | bit_mask;
      MODE_TRB: begin
        mask       = MASK_Z;
        z_from_and = 1'b1;
        res        = op_i.operand & ~op_i.acc;
      end
      MODE_TSB: begin
        mask       = MASK_Z;
        z_from_and = 1'b1;
        res        = op_i.operand | op_i.acc;
      end
      MODE_BBR: br = ((op_i.operand & bit_mask) == 8'd0);
      MODE_BBS: br = ((op_i.operand & bit_mask) != 8'd0);
      default: ;
    endcase

    // TRB and TSB test A AND memory rather than the written byte.
    if (z_from_and) begin
      zf = ((op_i.acc & op_i.operand) == 8'd0);
    end else begin
      zf = (res == 8'd0);
    end

    res_o.result       = res;
    res_o.carry_out    = cf & mask[FLAG_C];
    res_o.zero_out     = zf & mask[FLAG_Z];
    res_o.overflow_out = vf & mask[FLAG_V];
    res_o.negative_out = res[7] & mask[FLAG_N];
    res_o.flag_update  = mask;
    res_o.branch_taken = br;
  end

endmodule

/* src/cpu8_alu_bcd_rmw_core.sv */
// Top level of the 8-bit CPU ALU: input register, ALU logic, result register.
// Depends on c8alu_pkg and instantiates c8alu_exec.

// An item accepted at a clock edge is held in the input register, computed by the
// ALU logic and presented on the output from the result register, where it can be
// taken. One item can be accepted in every cycle for as long as results are taken.
// The block is a two-stage pipeline: the input register holds the operation,
// the ALU logic works on it combinationally, and the result register holds the
// answer until it is taken. in_stall_o rises only when both stages are full
// and out_stall_i is high, so a waiting result does not block the next item.
// There is no state beyond the pipeline and no reset sequence.
module cpu8_alu_bcd_rmw_core
  import c8alu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] mode_i,
  input  logic [7:0] acc_i,
  input  logic [7:0] operand_i,
  input  logic       carry_in_i,
  input  logic       decimal_i,
  input  logic [2:0] bit_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] result_o,
  output logic       carry_out_o,
  output logic       zero_out_o,
  output logic       overflow_out_o,
  output logic       negative_out_o,
  output logic [3:0] flag_update_o,
  output logic       branch_taken_o
);

  logic     op_valid_q;
  alu_op_t  op_q;
  logic     res_valid_q;
  alu_res_t res_q;
  alu_res_t res_d;
  logic     res_load;
  logic     op_load;

  c8alu_exec u_exec (
    .op_i  (op_q),
    .res_o (res_d)
  );

  // The result register takes a new item when it is empty or being drained.
  assign res_load   = ~res_valid_q | ~out_stall_i;
  assign in_stall_o = op_valid_q & ~res_load;
  assign op_load    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_q <= op_valid_q;
      end
      if (op_load) begin
        op_valid_q <= 1'b1;
      end else if (res_load) begin
        op_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_load) begin
      op_q.mode      <= mode_i;
      op_q.acc       <= acc_i;
      op_q.operand   <= operand_i;
      op_q.carry_in  <= carry_in_i;
      op_q.decimal   <= decimal_i;
      op_q.bit_index <= bit_index_i;
    end
    if (res_load && op_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign result_o       = res_q.result;
  assign carry_out_o    = res_q.carry_out;
  assign zero_out_o     = res_q.zero_out;
  assign overflow_out_o = res_q.overflow_out;
  assign negative_out_o = res_q.negative_out;
  assign flag_update_o  = res_q.flag_update;
  assign branch_taken_o = res_q.branch_taken;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (op_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline had room");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("a waiting result was dropped");

  a_item_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && !in_stall_o) |=> out_valid_o)
    else $error("an item in the input register did not reach the output");

  a_flags_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!(carry_out_o && !flag_update_o[FLAG_C])
                  && !(zero_out_o && !flag_update_o[FLAG_Z])
                  && !(overflow_out_o && !flag_update_o[FLAG_V])
                  && !(negative_out_o && !flag_update_o[FLAG_N])))
    else $error("a flag value is set but not in the update mask");

  a_branch_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && branch_taken_o) |-> (flag_update_o == MASK_NONE))
    else $error("branch bit set by an operation that writes flags");
`endif

endmodule

/* tb/cpu8_alu_bcd_rmw_core_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for cpu8_alu_bcd_rmw_core: directed and random ALU items
// checked against an in-bench predictor. Depends on c8alu_pkg and the core RTL.
module cpu8_alu_bcd_rmw_core_test;
  import c8alu_pkg::*;

  // Mode codes that the package leaves unassigned; the core treats them as no-ops.
  localparam logic [3:0] MODE_UNUSED_LO = 4'd14;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
  localparam int unsigned RANDOM_HALF    = 250;
  localparam int unsigned LONG_HOLD_AT   = 120;
  localparam int unsigned LONG_HOLD_LEN  = 150;
  localparam int unsigned SETTLE_CYCLES  = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [3:0] mode_i = MODE_ADC;
  logic [7:0] acc_i = 8'h00;
  logic [7:0] operand_i = 8'h00;
  logic       carry_in_i = 1'b0;
  logic       decimal_i = 1'b0;
  logic [2:0] bit_index_i = 3'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] result_o;
  logic       carry_out_o;
  logic       zero_out_o;
  logic       overflow_out_o;
  logic       negative_out_o;
  logic [3:0] flag_update_o;
  logic       branch_taken_o;

  alu_op_t      pending_ops[$];
  alu_res_t     expected_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  mode_hits[16];
  int unsigned  decimal_hits = 0;
  int unsigned  gap_left = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_run = 0;
  int unsigned  longest_in_stall = 0;
  int unsigned  hold_left = 0;
  bit           long_hold_done = 1'b0;
  int unsigned  pattern_left = 0;
  stall_style_e stall_style = STALL_NONE;

  cpu8_alu_bcd_rmw_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .acc_i,
    .operand_i,
    .carry_in_i,
    .decimal_i,
    .bit_index_i,
    .out_valid_o,
    .out_stall_i,
    .result_o,
    .carry_out_o,
    .zero_out_o,
    .overflow_out_o,
    .negative_out_o,
    .flag_update_o,
    .branch_taken_o
  );

  always #5 clk_i = ~clk_i;

  // Computes what the ALU must return for one operation.
  function automatic alu_res_t predict_alu(alu_op_t op);
    alu_res_t   r;
    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] bit_sel;
    logic [7:0] diff;
    logic [8:0] sum;
    logic [4:0] lo;
    logic [4:0] hi;
    logic       borrow;
    logic       digit_carry;
    r = '0;
    r.result = op.operand;
    a = op.acc;
    m = op.operand;
    bit_sel = 8'h01 << op.bit_index;
    case (op.mode)
      MODE_ADC, MODE_SBC: begin
        r.flag_update = MASK_ALL;
        if (op.decimal && op.mode == MODE_ADC) begin
          lo = a[3:0] + m[3:0] + op.carry_in;
          digit_carry = 1'b0;
          if (lo > BCD_MAX_DIGIT) begin
            lo = (lo + BCD_ADJ) & 5'h0F;
            digit_carry = 1'b1;
          end
          hi = a[7:4] + m[7:4] + digit_carry;
          // Overflow looks at the high digit before its decimal correction.
          r.overflow_out = (hi[3] ^ a[7]) & ~(a[7] ^ m[7]);
          r.carry_out = (hi > BCD_MAX_DIGIT);
          if (hi > BCD_MAX_DIGIT) hi = hi + BCD_ADJ;
          r.result = {hi[3:0], lo[3:0]};
        end else if (op.decimal) begin
          borrow = ~op.carry_in;
          diff = a - m - borrow;
          lo = a[3:0] - m[3:0] - borrow;
          digit_carry = 1'b0;
          if (lo[4]) begin
            lo = lo - BCD_ADJ;
            digit_carry = 1'b1;
          end
          hi = a[7:4] - m[7:4] - digit_carry;
          r.overflow_out = (m[7] ^ a[7]) & ~(diff[7] ^ m[7]);
          r.carry_out = ~hi[4];
          if (hi[4]) hi = hi - BCD_ADJ;
          r.result = {hi[3:0], lo[3:0]};
        end else begin
          if (op.mode == MODE_SBC) m = ~m;
          sum = a + m + op.carry_in;
          r.result = sum[7:0];
          r.carry_out = sum[8];
          r.overflow_out = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
        end
      end
      MODE_ASL: begin
        r.carry_out = m[7];
        r.result = {m[6:0], 1'b0};
        r.flag_update = MASK_CZN;
      end
      MODE_LSR: begin
        r.carry_out = m[0];
        r.result = {1'b0, m[7:1]};
        r.flag_update = MASK_CZN;
      end
      MODE_ROL: begin
        r.carry_out = m[7];
        r.result = {m[6:0], op.carry_in};
        r.flag_update = MASK_CZN;
      end
      MODE_ROR: begin
        r.carry_out = m[0];
        r.result = {op.carry_in, m[7:1]};
        r.flag_update = MASK_CZN;
      end
      MODE_INC: begin
        r.result = m + 8'h01;
        r.flag_update = MASK_ZN;
      end
      MODE_DEC: begin
        r.result = m - 8'h01;
        r.flag_update = MASK_ZN;
      end
      MODE_RMB: r.result = m & ~bit_sel;
      MODE_SMB: r.result = m | bit_sel;
      MODE_TRB: begin
        r.zero_out = ((a & m) == 8'h00);
        r.result = m & ~a;
        r.flag_update = MASK_Z;
      end
      MODE_TSB: begin
        r.zero_out = ((a & m) == 8'h00);
        r.result = m | a;
        r.flag_update = MASK_Z;
      end
      MODE_BBR: r.branch_taken = ((m & bit_sel) == 8'h00);
      MODE_BBS: r.branch_taken = ((m & bit_sel) != 8'h00);
      default: ;
    endcase
    // TRB and TSB take Z from the AND test; everything else takes it from the byte.
    if (r.flag_update[FLAG_Z] && op.mode != MODE_TRB && op.mode != MODE_TSB)
      r.zero_out = (r.result == 8'h00);
    if (r.flag_update[FLAG_N]) r.negative_out = r.result[7];
    r.carry_out    &= r.flag_update[FLAG_C];
    r.zero_out     &= r.flag_update[FLAG_Z];
    r.overflow_out &= r.flag_update[FLAG_V];
    r.negative_out &= r.flag_update[FLAG_N];
    return r;
  endfunction

  task automatic add_item(logic [3:0] mode, logic [7:0] acc, logic [7:0] operand,
                          logic carry, logic dec_mode, logic [2:0] bit_index);
    alu_op_t op;
    op.mode = mode;
    op.acc = acc;
    op.operand = operand;
    op.carry_in = carry;
    op.decimal = dec_mode;
    op.bit_index = bit_index;
    pending_ops.push_back(op);
  endtask

  // Mixes corner bytes, well-formed BCD bytes and arbitrary bytes.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[4];
    int unsigned roll;
    corners = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    roll = $urandom_range(0, 7);
    if (roll == 0) return corners[$urandom_range(0, 3)];
    if (roll <= 3) return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    return 8'($urandom);
  endfunction

  task automatic fill_random(int unsigned count);
    logic [3:0] mode;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) < 18) mode = 4'($urandom_range(MODE_ADC, MODE_BBS));
      else mode = $urandom_range(0, 1) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
      add_item(mode, pick_byte(), pick_byte(), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    end
  endtask

  function automatic bit drained();
    return pending_ops.size() == 0 && !in_valid_i && expected_results.size() == 0;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Sender: bursts of items separated by random gaps; an offered item is held until taken.
  always @(posedge clk_i) begin : drive_items
    alu_op_t next_op;
    alu_op_t taken_op;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) stall_run++;
      else stall_run = 0;
      if (stall_run > longest_in_stall) longest_in_stall = stall_run;
      if (in_valid_i && !in_stall_o) begin
        taken_op = {mode_i, acc_i, operand_i, carry_in_i, decimal_i, bit_index_i};
        expected_results.push_back(predict_alu(taken_op));
        mode_hits[mode_i]++;
        if (decimal_i && (mode_i == MODE_ADC || mode_i == MODE_SBC)) decimal_hits++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (burst_left == 0 && gap_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = $urandom_range(1, 40);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          in_valid_i  <= 1'b1;
          mode_i      <= next_op.mode;
          acc_i       <= next_op.acc;
          operand_i   <= next_op.operand;
          carry_in_i  <= next_op.carry_in;
          decimal_i   <= next_op.decimal;
          bit_index_i <= next_op.bit_index;
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken result and stalls in changing patterns.
  always @(posedge clk_i) begin : check_results
    alu_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result %0h arrived with nothing expected", $time, result_o);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result", want.result, result_o);
          check_field("carry_out", {7'd0, want.carry_out}, {7'd0, carry_out_o});
          check_field("zero_out", {7'd0, want.zero_out}, {7'd0, zero_out_o});
          check_field("overflow_out", {7'd0, want.overflow_out}, {7'd0, overflow_out_o});
          check_field("negative_out", {7'd0, want.negative_out}, {7'd0, negative_out_o});
          check_field("flag_update", {4'd0, want.flag_update}, {4'd0, flag_update_o});
          check_field("branch_taken", {7'd0, want.branch_taken}, {7'd0, branch_taken_o});
        end
      end
      // One long hold-off lets the pipeline fill so that the input side stalls.
      if (results_seen >= LONG_HOLD_AT && !long_hold_done) begin
        hold_left = LONG_HOLD_LEN;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          stall_style = stall_style_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(10, 60);
        end
        pattern_left--;
        case (stall_style)
          STALL_NONE:   out_stall_i <= 1'b0;
          STALL_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall_i <= ~out_stall_i;
          default:      out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned modes_covered;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners: signed overflow, carry and zero, decimal carries and
    // borrows, non-BCD digits, shifts at the edge bits, wraps, bit ops, no-ops.
    add_item(MODE_ADC, 8'h7F, 8'h01, 1'b0, 1'b0, 3'd0);
    add_item(MODE_ADC, 8'hFF, 8'h01, 1'b0, 1'b0, 3'd0);
    add_item(MODE_ADC, 8'h99, 8'h01, 1'b0, 1'b1, 3'd0);
    add_item(MODE_ADC, 8'h58, 8'h46, 1'b1, 1'b1, 3'd0);
    add_item(MODE_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd7);
    add_item(MODE_SBC, 8'h00, 8'h01, 1'b1, 1'b0, 3'd0);
    add_item(MODE_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 3'd0);
    add_item(MODE_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 3'd0);
    add_item(MODE_SBC, 8'h46, 8'h12, 1'b1, 1'b1, 3'd0);
    add_item(MODE_SBC, 8'hAB, 8'hFF, 1'b0, 1'b1, 3'd0);
    add_item(MODE_ASL, 8'h00, 8'h80, 1'b0, 1'b0, 3'd0);
    add_item(MODE_LSR, 8'h00, 8'h01, 1'b1, 1'b0, 3'd0);
    add_item(MODE_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 3'd0);
    add_item(MODE_ROR, 8'h00, 8'h01, 1'b1, 1'b0, 3'd0);
    add_item(MODE_INC, 8'h00, 8'hFF, 1'b0, 1'b0, 3'd0);
    add_item(MODE_DEC, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0);
    add_item(MODE_DEC, 8'h00, 8'h80, 1'b0, 1'b0, 3'd0);
    add_item(MODE_RMB, 8'h00, 8'hFF, 1'b0, 1'b0, 3'd7);
    add_item(MODE_SMB, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0);
    add_item(MODE_TRB, 8'h0F, 8'hF0, 1'b1, 1'b0, 3'd0);
    add_item(MODE_TSB, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd0);
    add_item(MODE_BBR, 8'h00, 8'hF7, 1'b1, 1'b0, 3'd3);
    add_item(MODE_BBS, 8'h00, 8'h80, 1'b0, 1'b0, 3'd7);
    add_item(MODE_UNUSED_LO, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd7);
    add_item(MODE_UNUSED_HI, 8'hFF, 8'h5A, 1'b1, 1'b1, 3'd7);

    // The sender pauses between phases until every result has come back.
    while (!drained()) @(negedge clk_i);
    fill_random(RANDOM_HALF);
    @(negedge clk_i);
    while (!drained()) @(negedge clk_i);
    fill_random(RANDOM_HALF);
    @(negedge clk_i);
    while (!drained()) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    modes_covered = 0;
    for (int i = 0; i < 16; i++) if (mode_hits[i] > 0) modes_covered++;
    $display("Run covered %0d results over %0d of 16 mode codes, %0d of them decimal ADC/SBC.",
             results_seen, modes_covered, decimal_hits);
    $display("Longest input stall lasted %0d cycles.", longest_in_stall);
    if (mismatch_count == 0) begin
      $display("[cpu8_alu_bcd_rmw_core] OK");
    end else begin
      $display("[cpu8_alu_bcd_rmw_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results still expected.", expected_results.size());
    $display("[cpu8_alu_bcd_rmw_core] ERROR");
    $finish;
  end

endmodule
